// ===== rtl/tbo_pkg.sv =====
// shared widths, result codes and controller/datapath interface structs
package tbo_pkg;

  localparam int TS_W      = 63;
  localparam int OFF_W     = 48;
  localparam int IV_W      = 32;
  localparam int STATUS_W  = 3;
  localparam int DIV_STEPS = TS_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [IV_W-1:0] IV_RESET = 32'd1000000000;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED   = 3'd0,
    ST_SKIPPED  = 3'd1,
    ST_INVALID  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    load;       // capture the request fields
    logic    first;      // first add on an empty index
    logic    div_init;   // load dividend, clear remainder
    logic    div_step;   // one restoring division step
    logic    fill_init;  // fill pointer to top bucket + 1
    logic    fill_step;  // write one bucket, advance pointer
    logic    commit;     // latest time and top bucket take new values
    logic    rd_issue;   // read the clamped bucket
    logic    reply;      // register the result and strobe done
    status_t code;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_add;
    logic invalid;
    logic empty;
    logic too_early;
    logic out_of_range;
    logic div_last;
    logic quot_full;
    logic fill_done;
  } dp_stat_t;

endpackage

// ===== rtl/time_bucket_offset_index.sv =====
// top level of the time bucket to file offset index
// invalid, skipped, not-found and first-add requests are answered from the check state
// lookups go on through divide, decide and a table read; other adds divide, then report full or fill
// the 63-step serial divider runs on both paths; the fill loop writes one table entry a cycle
// throughput: one request at a time, the next is taken in the cycle that done is high
// reset: index empty, interval back to its default, table undefined; results never stall
module time_bucket_offset_index #(
  parameter int DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [tbo_pkg::TS_W-1:0]     timestamp,
  input  logic [tbo_pkg::OFF_W-1:0]    offset,
  // bucket width register
  input  logic                         interval_we,
  input  logic [tbo_pkg::IV_W-1:0]     interval_wdata,
  // result, valid for the one cycle that done is high
  output logic                         done,
  output logic [tbo_pkg::STATUS_W-1:0] status,
  output logic [tbo_pkg::OFF_W-1:0]    found_offset,
  output logic [tbo_pkg::TS_W-1:0]     first_time,
  output logic [tbo_pkg::TS_W-1:0]     last_time
);
  import tbo_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller walks check, divide, decide, then fill or read
  tbo_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // index state, divider and bucket table
  tbo_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .operation      (operation),
    .timestamp      (timestamp),
    .offset         (offset),
    .interval_we    (interval_we),
    .interval_wdata (interval_wdata),
    .done           (done),
    .status         (status),
    .found_offset   (found_offset),
    .first_time     (first_time),
    .last_time      (last_time)
  );

  // an accepted request always makes the block busy in the next cycle
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // the result strobe only comes once the request is finished
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still busy");

  // two results never come back to back
  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // offset only reported on a found lookup
  a_offset_zero : assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_FOUND) |-> found_offset == '0)
    else $error("offset reported without a found lookup");

  // a stored add or a found lookup means the index is not empty
  a_nonempty : assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_STORED || status == ST_FOUND) |-> first_time != '0)
    else $error("index empty after stored or found result");

endmodule

// ===== rtl/tbo_ctrl.sv =====
// sequencing state machine for the time bucket index
module tbo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tbo_pkg::dp_stat_t stat,
  output tbo_pkg::dp_cmd_t  cmd
);
  import tbo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVIDE,
    S_DECIDE,
    S_FILL,
    S_RDWAIT
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_STORED;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_add) begin
          if (stat.invalid) begin
            cmd.reply  = 1'b1;
            cmd.code   = ST_INVALID;
            state_next = S_IDLE;
          end else if (stat.empty) begin
            cmd.first  = 1'b1;
            cmd.reply  = 1'b1;
            cmd.code   = ST_STORED;
            state_next = S_IDLE;
          end else if (stat.too_early) begin
            cmd.reply  = 1'b1;
            cmd.code   = ST_SKIPPED;
            state_next = S_IDLE;
          end else begin
            cmd.div_init = 1'b1;
            state_next   = S_DIVIDE;
          end
        end else if (stat.out_of_range) begin
          cmd.reply  = 1'b1;
          cmd.code   = ST_NOTFOUND;
          state_next = S_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_add) begin
          if (stat.quot_full) begin
            cmd.reply  = 1'b1;
            cmd.code   = ST_FULL;
            state_next = S_IDLE;
          end else begin
            cmd.fill_init = 1'b1;
            state_next    = S_FILL;
          end
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_RDWAIT;
        end
      end
      S_FILL: begin
        if (stat.fill_done) begin
          cmd.commit = 1'b1;
          cmd.reply  = 1'b1;
          cmd.code   = ST_STORED;
          state_next = S_IDLE;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      S_RDWAIT: begin
        cmd.reply  = 1'b1;
        cmd.code   = ST_FOUND;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/tbo_dp.sv =====
// datapath: index state, serial divider, bucket table and result registers
module tbo_dp #(
  parameter int DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tbo_pkg::dp_cmd_t             cmd,
  output tbo_pkg::dp_stat_t            stat,
  input  logic                         operation,
  input  logic [tbo_pkg::TS_W-1:0]     timestamp,
  input  logic [tbo_pkg::OFF_W-1:0]    offset,
  input  logic                         interval_we,
  input  logic [tbo_pkg::IV_W-1:0]     interval_wdata,
  output logic                         done,
  output logic [tbo_pkg::STATUS_W-1:0] status,
  output logic [tbo_pkg::OFF_W-1:0]    found_offset,
  output logic [tbo_pkg::TS_W-1:0]     first_time,
  output logic [tbo_pkg::TS_W-1:0]     last_time
);
  import tbo_pkg::*;

  localparam int AW = $clog2(DEPTH);

  // configuration and index state
  logic [IV_W-1:0]  interval;
  logic [TS_W-1:0]  start_time;
  logic [TS_W-1:0]  latest_time;
  logic [AW-1:0]    top_bucket;

  // captured request
  logic             op;
  logic [TS_W-1:0]  ts;
  logic [OFF_W-1:0] off;

  // divider
  logic [IV_W-1:0]  rem;
  logic [TS_W-1:0]  quot;
  logic [CNT_W-1:0] cnt;

  // fill and table
  logic [AW:0]      ptr;
  logic [OFF_W-1:0] mem [DEPTH];
  logic [OFF_W-1:0] rdata;

  logic [IV_W-1:0]  iv_eff;
  logic [TS_W-1:0]  iv_ext;
  logic [TS_W-1:0]  gap;
  logic [IV_W:0]    trial;
  logic             trial_ge;
  logic [IV_W:0]    trial_sub;
  logic [AW-1:0]    bucket;
  logic [AW-1:0]    rd_addr;
  logic             wen;
  logic [AW-1:0]    waddr;

  // a zero interval acts as one
  assign iv_eff = (interval == '0) ? IV_W'(1) : interval;
  assign iv_ext = {{(TS_W-IV_W){1'b0}}, iv_eff};
  assign gap    = ts - latest_time;

  assign stat.is_add       = ~op;
  assign stat.invalid      = (ts == '0) || (off == '0);
  assign stat.empty        = (start_time == '0);
  assign stat.too_early    = (ts < latest_time) || (gap < iv_ext);
  assign stat.out_of_range = (start_time == '0) || (ts > latest_time) || (ts < start_time);
  assign stat.div_last     = (cnt == '0);
  assign stat.quot_full    = (quot >= TS_W'(DEPTH));
  assign stat.fill_done    = (ptr > {1'b0, bucket});

  // restoring division, one quotient bit per step
  assign trial     = {rem, quot[TS_W-1]};
  assign trial_ge  = (trial >= {1'b0, iv_eff});
  assign trial_sub = trial - {1'b0, iv_eff};

  assign bucket  = quot[AW-1:0];
  // clamp lookup to the last filled bucket
  assign rd_addr = (quot > {{(TS_W-AW){1'b0}}, top_bucket}) ? top_bucket : quot[AW-1:0];

  assign wen   = cmd.first | cmd.fill_step;
  assign waddr = cmd.first ? '0 : ptr[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      interval    <= IV_RESET;
      start_time  <= '0;
      latest_time <= '0;
      top_bucket  <= '0;
      done        <= 1'b0;
      status      <= ST_STORED;
      found_offset <= '0;
    end else begin
      if (interval_we) begin
        interval <= interval_wdata;
      end
      if (cmd.first) begin
        start_time  <= ts;
        latest_time <= ts;
        top_bucket  <= '0;
      end
      if (cmd.commit) begin
        latest_time <= ts;
        top_bucket  <= bucket;
      end
      done <= cmd.reply;
      if (cmd.reply) begin
        status       <= cmd.code;
        found_offset <= (cmd.code == ST_FOUND) ? rdata : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= operation;
      ts  <= timestamp;
      off <= offset;
    end
    if (cmd.div_init) begin
      quot <= ts - start_time;
      rem  <= '0;
      cnt  <= CNT_W'(DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? trial_sub[IV_W-1:0] : trial[IV_W-1:0];
      quot <= {quot[TS_W-2:0], trial_ge};
      cnt  <= cnt - CNT_W'(1);
    end
    if (cmd.fill_init) begin
      ptr <= {1'b0, top_bucket} + (AW+1)'(1);
    end else if (cmd.fill_step) begin
      ptr <= ptr + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= off;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rdata <= mem[rd_addr];
    end
  end

  assign first_time = start_time;
  assign last_time  = latest_time;

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the time bucket offset index
module testbench;
  import tbo_pkg::*;

  localparam int SLOTS        = 4096;   // table depth of the instance
  localparam int RESET_CYCLES = 8;
  localparam int QUIET_LIMIT  = 20000;  // limit for the hung-run watchdog
  localparam int DRAIN_CYCLES = 100;    // settle time after the last result
  localparam int PRINT_LIMIT  = 40;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 75;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [TS_W-1:0]  TS_MAX    = '1;
  localparam logic [OFF_W-1:0] OFF_MAX   = '1;
  localparam logic [IV_W-1:0]  IV_MAX    = '1;
  localparam logic [IV_W-1:0]  IV_COARSE = 32'd1000;
  localparam logic [IV_W-1:0]  IV_FINE   = 32'd7;

  // one expected result
  typedef struct {
    status_t          code;
    logic [OFF_W-1:0] found;
    logic [TS_W-1:0]  first;
    logic [TS_W-1:0]  last;
  } outcome_t;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                start          = 1'b0;
  logic                busy;
  logic                operation      = OP_ADD;
  logic [TS_W-1:0]     timestamp      = '0;
  logic [OFF_W-1:0]    offset         = '0;
  logic                interval_we    = 1'b0;
  logic [IV_W-1:0]     interval_wdata = '0;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    found_offset;
  logic [TS_W-1:0]     first_time;
  logic [TS_W-1:0]     last_time;

  // mirror of the index contents, updated as each request is accepted
  logic [TS_W-1:0]  origin_ts    = '0;        // zero while the index is empty
  logic [TS_W-1:0]  newest_ts    = '0;
  int               top_slot     = 0;
  logic [OFF_W-1:0] slot_offset [SLOTS];
  logic [IV_W-1:0]  bucket_width = IV_RESET;

  outcome_t    outcome_q[$];                  // expected results, oldest first
  int          mismatch_count = 0;
  int          idle_pct       = 0;            // chance in percent of an idle cycle
  int unsigned quiet_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  time_bucket_offset_index #(
    .DEPTH(SLOTS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .timestamp      (timestamp),
    .offset         (offset),
    .interval_we    (interval_we),
    .interval_wdata (interval_wdata),
    .done           (done),
    .status         (status),
    .found_offset   (found_offset),
    .first_time     (first_time),
    .last_time      (last_time)
  );

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // nonzero random offset
  function automatic logic [OFF_W-1:0] rand_offset();
    logic [OFF_W-1:0] v;
    v = OFF_W'(rand_word());
    if (v == '0) begin
      v = OFF_W'(1);
    end
    return v;
  endfunction

  // a zero width divides as one
  function automatic logic [63:0] eff_width();
    return (bucket_width == '0) ? 64'd1 : 64'(bucket_width);
  endfunction

  // result of one request against the mirrored index; updates the mirror
  function automatic outcome_t predict_outcome(logic op, logic [TS_W-1:0] ts,
                                               logic [OFF_W-1:0] off);
    outcome_t   res;
    logic [63:0] width;
    logic [63:0] slot;
    int          k;
    width     = eff_width();
    res.found = '0;
    res.code  = ST_STORED;
    if (op == OP_ADD) begin
      if (ts == '0 || off == '0) begin
        res.code = ST_INVALID;
      end else if (origin_ts == '0) begin
        // first entry opens bucket 0
        origin_ts      = ts;
        newest_ts      = ts;
        top_slot       = 0;
        slot_offset[0] = off;
      end else if (ts < newest_ts || ({1'b0, ts} - {1'b0, newest_ts}) < width) begin
        res.code = ST_SKIPPED;
      end else begin
        slot = ({1'b0, ts} - {1'b0, origin_ts}) / width;
        if (slot >= 64'(SLOTS)) begin
          res.code = ST_FULL;
        end else begin
          // buckets not above the top are left alone, the top still moves
          for (k = top_slot + 1; k <= int'(slot); k++) begin
            slot_offset[k] = off;
          end
          newest_ts = ts;
          top_slot  = int'(slot);
        end
      end
    end else begin
      if (origin_ts == '0 || ts > newest_ts || ts < origin_ts) begin
        res.code = ST_NOTFOUND;
      end else begin
        slot = ({1'b0, ts} - {1'b0, origin_ts}) / width;
        if (slot > 64'(top_slot)) begin
          slot = 64'(top_slot);
        end
        if (slot >= 64'(SLOTS)) begin
          slot = 64'(SLOTS - 1);
        end
        res.code  = ST_FOUND;
        res.found = slot_offset[int'(slot)];
      end
    end
    res.first = origin_ts;
    res.last  = newest_ts;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // drive one request, wait for the handshake, record what should come back
  task automatic send_request(logic op, logic [TS_W-1:0] ts, logic [OFF_W-1:0] off);
    @(posedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    timestamp <= ts;
    offset    <= off;
    // busy sampled before the edge decides acceptance
    do begin
      @(posedge clk);
    end while (busy);
    outcome_q.push_back(predict_outcome(op, ts, off));
    start <= 1'b0;
  endtask

  task automatic wait_idle();
    while (outcome_q.size() != 0 || busy) begin
      @(posedge clk);
    end
  endtask

  // bucket width write, only with nothing in flight
  task automatic set_interval(logic [IV_W-1:0] value);
    wait_idle();
    @(posedge clk);
    interval_we    <= 1'b1;
    interval_wdata <= value;
    @(posedge clk);
    interval_we    <= 1'b0;
    bucket_width    = value;
  endtask

  // lookups and malformed adds before anything is stored
  task automatic test_empty_index();
    idle_pct = 0;
    send_request(OP_LOOKUP, '0, rand_offset());
    send_request(OP_LOOKUP, TS_MAX, rand_offset());
    send_request(OP_ADD, '0, rand_offset());
    send_request(OP_ADD, TS_MAX, '0);
    send_request(OP_ADD, '0, '0);
  endtask

  // first entry, early adds, fills and the end of the table
  task automatic test_first_entry();
    logic [TS_W-1:0] s;
    s = {1'b0, 30'($urandom_range(1, 32'h3FFF_FFFF)), 32'($urandom)};
    idle_pct = 16;
    set_interval('0);                            // zero width acts as one
    send_request(OP_ADD, s, OFF_MAX);
    send_request(OP_LOOKUP, s, rand_offset());
    send_request(OP_LOOKUP, s - 1, rand_offset());  // before the first entry
    send_request(OP_LOOKUP, s + 1, rand_offset());  // past the latest entry
    send_request(OP_ADD, s, rand_offset());         // same time, too early
    send_request(OP_ADD, 1, rand_offset());         // behind the latest entry
    send_request(OP_ADD, s + 1, 1);                 // smallest valid offset
    send_request(OP_ADD, s + 6, rand_offset());     // fills several buckets
    send_request(OP_LOOKUP, s + 4, rand_offset());
    send_request(OP_ADD, s + TS_W'(SLOTS), rand_offset()); // first bucket past the table
    send_request(OP_ADD, TS_MAX, rand_offset());
    set_interval(32'd1);
    send_request(OP_ADD, s + TS_W'(SLOTS - 1), rand_offset());  // fills to the last bucket
    send_request(OP_LOOKUP, s + TS_W'(SLOTS - 1), rand_offset());
  endtask

  // width changes move the top bucket and the lookup clamp
  task automatic test_interval_change();
    idle_pct = 84;
    set_interval(IV_COARSE);
    // new bucket lands below the top: no write, top drops
    send_request(OP_ADD, newest_ts + TS_W'(IV_COARSE), rand_offset());
    send_request(OP_LOOKUP, origin_ts + 4000, rand_offset());
    send_request(OP_LOOKUP, newest_ts, rand_offset());
    send_request(OP_ADD, newest_ts + 2500, rand_offset());
    send_request(OP_LOOKUP, newest_ts, rand_offset());
    // narrower width pushes lookups above the top bucket
    set_interval(IV_FINE);
    send_request(OP_LOOKUP, newest_ts, rand_offset());
    send_request(OP_LOOKUP, origin_ts + 3, rand_offset());
  endtask

  // one width setting, mostly well-formed adds and in-range lookups
  task automatic random_phase(int items, logic [IV_W-1:0] width);
    logic [63:0]      w;
    logic [63:0]      ts;
    logic [63:0]      span;
    logic [OFF_W-1:0] off;
    logic             op;
    int               pick;
    int               k;
    set_interval(width);
    repeat (items) begin
      w    = eff_width();
      span = {1'b0, newest_ts} - {1'b0, origin_ts};
      op   = OP_ADD;
      off  = rand_offset();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // next entry a few buckets on, now and then a long jump
        k  = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
        ts = {1'b0, newest_ts} + w * 64'(k) + rand_word() % w;
      end else if (pick < 72) begin
        op = OP_LOOKUP;
        ts = {1'b0, origin_ts} + rand_word() % (span + 64'd1);
      end else if (pick < 78) begin
        op = OP_LOOKUP;
        if ($urandom_range(0, 1) == 0) begin
          ts = rand_word() % {1'b0, origin_ts};
        end else begin
          ts = {1'b0, newest_ts} + 64'd1 + rand_word() % (w * 64'd8);
        end
      end else if (pick < 85) begin
        // less than one width after the latest, or behind it
        if ($urandom_range(0, 1) == 0) begin
          ts = {1'b0, newest_ts} + rand_word() % w;
        end else begin
          ts = rand_word() % {1'b0, newest_ts};
        end
      end else if (pick < 90) begin
        ts = rand_word() >> 1;
        case ($urandom_range(0, 2))
          0: ts = '0;
          1: off = '0;
          default: begin
            ts  = '0;
            off = '0;
          end
        endcase
      end else if (pick < 95) begin
        if ($urandom_range(0, 3) == 0) begin
          ts = {1'b0, TS_MAX};
        end else begin
          ts = {1'b0, origin_ts} + w * 64'(SLOTS + $urandom_range(0, 100))
               + rand_word() % w;
        end
      end else begin
        op = OP_LOOKUP;
        ts = rand_word() >> 1;
      end
      send_request(op, ts[TS_W-1:0], off);
    end
  endtask

  // widths chosen so the stored span covers at most half the table, unless capped at the largest width
  task automatic test_random_traffic();
    logic [63:0] need;
    logic [63:0] w;
    int          ph;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        1: idle_pct = 84;
        3: idle_pct = 16;
        default: idle_pct = 0;
      endcase
      need = ({1'b0, newest_ts} - {1'b0, origin_ts}) / 64'(SLOTS / 2) + 64'd1;
      w    = need + rand_word() % (need * 64'd3 + 64'd1);
      if (w > 64'(IV_MAX)) begin
        w = 64'(IV_MAX);
      end
      if (ph == PHASES - 2 && need <= 64'(IV_RESET)) begin
        w = 64'(IV_RESET);
      end
      if (ph == PHASES - 1) begin
        w = 64'(IV_MAX);
      end
      random_phase(PHASE_ITEMS, w[IV_W-1:0]);
    end
  endtask

  // every strobed result against the oldest expectation
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unrequested result status", 64'(status), '0);
      end else begin
        want = outcome_q.pop_front();
        if (status !== want.code) begin
          report_mismatch("status", 64'(status), 64'(want.code));
        end
        if (found_offset !== want.found) begin
          report_mismatch("found_offset", 64'(found_offset), 64'(want.found));
        end
        if (first_time !== want.first) begin
          report_mismatch("first_time", 64'(first_time), 64'(want.first));
        end
        if (last_time !== want.last) begin
          report_mismatch("last_time", 64'(last_time), 64'(want.last));
        end
      end
    end
  end

  // stop a hung run: nothing accepted on either side for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_empty_index();
    test_first_entry();
    test_interval_change();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
